// ===== src/config_frame_handler_top_defines.svh =====
// assertion macros shared by the config frame handler checker
// no dependencies; included by files that assert
`ifndef CONFIG_FRAME_HANDLER_TOP_DEFINES_SVH
`define CONFIG_FRAME_HANDLER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CFH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfh check failed");

// next-cycle implication, disabled in reset
`define CFH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfh check failed");

`endif

// ===== src/cfh_pkg.sv =====
// shared types, constants and helpers for the config frame handler
// no dependencies
`default_nettype none

package cfh_pkg;

   localparam int SETTING_BYTES = 16;
   localparam int HEADER_BYTES  = 6;

   // two banks: the live store and the pending write buffer
   localparam int MEM_DEPTH = 2 * SETTING_BYTES;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int IDX_W     = $clog2(SETTING_BYTES);
   localparam int POS_W     = 6;
   localparam int HDR_IDX_W = $clog2(HEADER_BYTES);

   localparam logic [7:0] CMD_READ   = 8'hF0;
   localparam logic [7:0] CMD_WRITE  = 8'h90;
   localparam logic [7:0] REPLY_MARK = 8'h24;

   localparam logic [7:0] FRAME_HEADER [HEADER_BYTES] =
      '{8'hFF, 8'h56, 8'hAE, 8'h35, 8'hA9, 8'h55};

   typedef struct packed {
      logic go;      // a result run starts
      logic reject;  // run is a single reject result
   } cfh_launch_type;

   typedef struct packed {
      logic bank;    // bank holding the live settings
      logic loaded;  // store has been written since reset
   } cfh_store_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } cfh_wr_type;

   function automatic logic [7:0] header_byte(input logic [HDR_IDX_W-1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      if (int'(idx) < HEADER_BYTES) b = FRAME_HEADER[idx];
      return b;
   endfunction

   function automatic logic [ADDR_W-1:0] bank_addr(input logic bank,
                                                   input logic [POS_W-1:0] idx);
      logic [ADDR_W-1:0] base;
      base = bank ? ADDR_W'(SETTING_BYTES) : '0;
      return base + ADDR_W'(idx);
   endfunction

endpackage

`default_nettype wire

// ===== src/cfh_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module cfh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/cfh_parser.sv =====
// frame parser: header match, control decode, write collection and bank commit
// depends on cfh_pkg
`default_nettype none

module cfh_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic [7:0]             rx_byte,
   input  wire logic                   frame_start,
   output cfh_pkg::cfh_launch_type     launch,
   output cfh_pkg::cfh_store_type      store,
   output cfh_pkg::cfh_wr_type         wr
);
   import cfh_pkg::*;

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_CONTROL = 2'd2;
   localparam logic [1:0] PH_DATA    = 2'd3;

   logic [1:0]       phase_ff, phase_in, phase_eff;
   logic [POS_W-1:0] pos_ff, pos_in, pos_eff, pos_inc;
   logic             bank_ff, bank_in;
   logic             loaded_ff, loaded_in;

   always_comb begin
      phase_eff = frame_start ? PH_HEADER : phase_ff;
      pos_eff   = frame_start ? '0 : pos_ff;
      pos_inc   = pos_eff + POS_W'(1);

      phase_in  = phase_ff;
      pos_in    = pos_ff;
      bank_in   = bank_ff;
      loaded_in = loaded_ff;
      launch    = '0;
      wr.en     = 1'b0;
      wr.addr   = bank_addr(~bank_ff, pos_eff);
      wr.data   = rx_byte;

      if (accept) begin
         unique case (phase_eff)
            PH_HEADER: begin
               if (int'(pos_eff) >= HEADER_BYTES ||
                   rx_byte != header_byte(pos_eff[HDR_IDX_W-1:0])) begin
                  launch   = '{go: 1'b1, reject: 1'b1};
                  phase_in = PH_IDLE;
                  pos_in   = '0;
               end else if (int'(pos_inc) >= HEADER_BYTES) begin
                  phase_in = PH_CONTROL;
                  pos_in   = '0;
               end else begin
                  phase_in = PH_HEADER;
                  pos_in   = pos_inc;
               end
            end
            PH_CONTROL: begin
               pos_in = '0;
               if (rx_byte == CMD_READ) begin
                  launch   = '{go: 1'b1, reject: 1'b0};
                  phase_in = PH_IDLE;
               end else if (rx_byte == CMD_WRITE) begin
                  phase_in = PH_DATA;
               end else begin
                  launch   = '{go: 1'b1, reject: 1'b1};
                  phase_in = PH_IDLE;
               end
            end
            PH_DATA: begin
               // collect into the pending bank, swap banks on the last byte
               wr.en = 1'b1;
               if (pos_inc == POS_W'(SETTING_BYTES)) begin
                  bank_in   = ~bank_ff;
                  loaded_in = 1'b1;
                  launch    = '{go: 1'b1, reject: 1'b0};
                  phase_in  = PH_IDLE;
                  pos_in    = '0;
               end else begin
                  phase_in = PH_DATA;
                  pos_in   = pos_inc;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               pos_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pos_ff    <= '0;
         bank_ff   <= 1'b0;
         loaded_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         bank_ff   <= bank_in;
         loaded_ff <= loaded_in;
      end
   end

   assign store = '{bank: bank_ff, loaded: loaded_ff};

endmodule

`default_nettype wire

// ===== src/config_frame_handler_top.sv =====
// config frame handler top level: parser, two-bank settings ram, reply sequencer
// depends on cfh_pkg, cfh_parser, cfh_ram
`default_nettype none

// A request carries one frame byte; frame_start marks header byte 0. Bytes that
// only advance the parse give no result and leave req_ready high. The byte that
// finishes a frame starts a run: either one reject result, or the reply mark
// followed by SETTING_BYTES (16) stored bytes, one result per cycle while rsp_ready
// is high. The stored bytes stream out of the registered read port of the settings
// ram, which holds two banks: the live settings and a pending buffer that a write
// frame fills; the last write byte swaps the banks, so an aborted write leaves the
// live settings untouched. While a run is in flight no request is taken (req_ready
// low). The store reads as all zero after reset through a loaded flag, so there is
// no clearing pass.

module config_frame_handler_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_frame_start,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_tx_byte,
   output logic            rsp_tx_last,
   output logic            rsp_rejected
);
   import cfh_pkg::*;

   // what the output stage is showing
   localparam logic [1:0] OUT_REJECT = 2'd0;
   localparam logic [1:0] OUT_MARK   = 2'd1;
   localparam logic [1:0] OUT_DATA   = 2'd2;

   cfh_launch_type    launch;
   cfh_store_type     store;
   cfh_wr_type        wr;

   logic              req_accept;
   logic              rsp_accept;
   logic              out_valid_ff, out_valid_in;
   logic [1:0]        out_mode_ff, out_mode_in;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in, rd_idx;
   logic              idx_at_end;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   // one request at a time: nothing enters while a result run is pending
   assign req_ready  = !out_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign rsp_accept = out_valid_ff && rsp_ready;

   cfh_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .rx_byte     (req_rx_byte),
      .frame_start (req_frame_start),
      .launch      (launch),
      .store       (store),
      .wr          (wr)
   );

   assign idx_at_end = (out_idx_ff == IDX_W'(SETTING_BYTES - 1));

   // read address runs one ahead on accept so the ram output tracks the shown byte
   always_comb begin
      rd_idx = out_idx_ff;
      if (rsp_accept && out_mode_ff == OUT_DATA && !idx_at_end) begin
         rd_idx = out_idx_ff + IDX_W'(1);
      end
      rd_addr = bank_addr(store.bank, POS_W'(rd_idx));
   end

   cfh_ram #(
      .WIDTH (8),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result run sequencer
   always_comb begin
      out_valid_in = out_valid_ff;
      out_mode_in  = out_mode_ff;
      out_idx_in   = out_idx_ff;
      if (launch.go) begin
         out_valid_in = 1'b1;
         out_mode_in  = launch.reject ? OUT_REJECT : OUT_MARK;
         out_idx_in   = '0;
      end else if (rsp_accept) begin
         unique case (out_mode_ff)
            OUT_MARK: begin
               out_mode_in = OUT_DATA;
            end
            OUT_DATA: begin
               if (idx_at_end) out_valid_in = 1'b0;
               else            out_idx_in   = rd_idx;
            end
            default: begin
               out_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_mode_ff  <= OUT_REJECT;
         out_idx_ff   <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         out_mode_ff  <= out_mode_in;
         out_idx_ff   <= out_idx_in;
      end
   end

   // payload: mark, stored byte (zero until the first write commit) or reject
   always_comb begin
      rsp_tx_byte  = 8'h00;
      rsp_tx_last  = 1'b0;
      rsp_rejected = 1'b0;
      unique case (out_mode_ff)
         OUT_MARK: begin
            rsp_tx_byte = REPLY_MARK;
         end
         OUT_DATA: begin
            rsp_tx_byte = store.loaded ? rd_data : 8'h00;
            rsp_tx_last = idx_at_end;
         end
         default: begin
            rsp_tx_last  = 1'b1;
            rsp_rejected = 1'b1;
         end
      endcase
   end

   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

// ===== src/cfh_checker.sv =====
// port-level checks for the config frame handler, bound to the top level
// depends on config_frame_handler_top_defines.svh and config_frame_handler_top
`default_nettype none
`include "config_frame_handler_top_defines.svh"

module cfh_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_tx_byte,
   input wire logic       rsp_tx_last,
   input wire logic       rsp_rejected
);

   // a pending result holds until taken
   `CFH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CFH_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_tx_byte))
   // no request taken while a result run is in flight
   `CFH_ASSERT_NOW(a_one_at_a_time, clock, reset, rsp_valid, !req_ready)
   // a reject is a single zero-byte final result
   `CFH_ASSERT_NOW(a_reject_shape, clock, reset, rsp_valid && rsp_rejected,
                   rsp_tx_last && rsp_tx_byte == 8'h00)
   // the run ends after its last result is taken
   `CFH_ASSERT_NEXT(a_run_ends, clock, reset, rsp_valid && rsp_ready && rsp_tx_last,
                    !rsp_valid)

endmodule

bind config_frame_handler_top cfh_checker u_cfh_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_tx_byte  (rsp_tx_byte),
   .rsp_tx_last  (rsp_tx_last),
   .rsp_rejected (rsp_rejected)
);

`default_nettype wire

// ===== test/config_frame_handler_top_tb.sv =====
// self-checking testbench for config_frame_handler_top: frame bytes in, reply bytes out
// depends on cfh_pkg for the header, command codes and store size
`default_nettype none

module config_frame_handler_top_tb;
   import cfh_pkg::*;

   // parser phases as the frame walks through the predictor
   typedef enum logic [1:0] {
      PARSE_IDLE,
      PARSE_HEADER,
      PARSE_CONTROL,
      PARSE_DATA
   } parse_phase_type;

   // one request waiting to be sent; hold_off makes the sender drain all replies first
   typedef struct {
      logic [7:0] rx_byte;
      logic       frame_start;
      bit         hold_off;
   } frame_byte_type;

   // one reply byte as it should leave the block
   typedef struct {
      logic [7:0] tx_byte;
      logic       tx_last;
      logic       rejected;
   } tx_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       req_frame_start = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_tx_byte;
   logic       rsp_tx_last;
   logic       rsp_rejected;

   // requests still to send, and reply bytes still to arrive
   frame_byte_type byte_feed_q[$];
   tx_result_type  awaited_tx_q[$];

   // predictor state: parse position, live settings and the write buffer
   parse_phase_type parse_phase;
   int              parse_pos;
   logic [7:0]      live_settings [SETTING_BYTES];
   logic [7:0]      staged_settings [SETTING_BYTES];

   int error_count = 0;
   int stimulus_count = 0;
   int tx_seen = 0;
   bit req_done = 1'b0;    // request taken at the last rising edge
   bit tail_calm = 1'b0;   // end of the run: no gaps, no stalls
   int send_gap = 0;
   int stall_left = 0;

   config_frame_handler_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_tx_last     (rsp_tx_last),
      .rsp_rejected    (rsp_rejected)
   );

   always #6 clock = ~clock;

   task automatic report_error(input string msg);
      $display("error at %0t: %s", $time, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // a refused frame gives a single zero byte flagged last and rejected
   task automatic queue_reject();
      awaited_tx_q.push_back('{8'h00, 1'b1, 1'b1});
      parse_phase = PARSE_IDLE;
      parse_pos = 0;
   endtask

   // reply mark, then every live setting, the last one flagged
   task automatic queue_settings_reply();
      awaited_tx_q.push_back('{REPLY_MARK, 1'b0, 1'b0});
      for (int k = 0; k < SETTING_BYTES; k++)
         awaited_tx_q.push_back('{live_settings[k], logic'(k == SETTING_BYTES - 1), 1'b0});
      parse_phase = PARSE_IDLE;
      parse_pos = 0;
   endtask

   task automatic parse_frame_byte(input logic [7:0] b, input logic start);
      // a frame start always restarts at header byte 0, dropping any partial write
      if (start) begin
         parse_phase = PARSE_HEADER;
         parse_pos = 0;
      end
      case (parse_phase)
         PARSE_HEADER: begin
            if (b != FRAME_HEADER[parse_pos]) begin
               queue_reject();
            end else begin
               parse_pos++;
               if (parse_pos == HEADER_BYTES) begin
                  parse_phase = PARSE_CONTROL;
                  parse_pos = 0;
               end
            end
         end
         PARSE_CONTROL: begin
            if (b == CMD_READ) begin
               queue_settings_reply();
            end else if (b == CMD_WRITE) begin
               parse_phase = PARSE_DATA;
               parse_pos = 0;
            end else begin
               queue_reject();
            end
         end
         PARSE_DATA: begin
            staged_settings[parse_pos] = b;
            parse_pos++;
            // settings change only once the whole write has come in
            if (parse_pos == SETTING_BYTES) begin
               live_settings = staged_settings;
               queue_settings_reply();
            end
         end
         default: ;   // idle: bytes without a frame start are dropped
      endcase
   endtask

   // ---------------------------------------------------------------
   // stimulus builders
   // ---------------------------------------------------------------

   task automatic queue_byte(input logic [7:0] b, input logic start, input bit hold,
                             input bit ignored);
      byte_feed_q.push_back('{b, start, hold});
      if (!ignored) stimulus_count++;
   endtask

   // first n header bytes, frame start on byte 0
   task automatic queue_header(input int n, input bit hold);
      for (int k = 0; k < n; k++)
         queue_byte(FRAME_HEADER[k], logic'(k == 0), hold && k == 0, 1'b0);
   endtask

   // ---------------------------------------------------------------
   // request driver: changes inputs at the falling edge
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      frame_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_done) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (byte_feed_q.size() == 0 ||
                      (byte_feed_q[0].hold_off && awaited_tx_q.size() != 0)) begin
            // nothing left, or this request waits until every reply is in
            req_valid <= 1'b0;
         end else begin
            nxt = byte_feed_q.pop_front();
            req_rx_byte     <= nxt.rx_byte;
            req_frame_start <= nxt.frame_start;
            req_valid       <= 1'b1;
            if (!tail_calm && $urandom_range(0, 4) == 0)
               send_gap = $urandom_range(1, 18);
         end
      end
   end

   // receiver back-pressure in random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!tail_calm && $urandom_range(0, 6) == 0)
            stall_left = $urandom_range(1, 18);
      end
   end

   // ---------------------------------------------------------------
   // monitor: samples both channels at the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      tx_result_type want;
      if (reset) begin
         req_done = 1'b0;
         parse_phase = PARSE_IDLE;
         parse_pos = 0;
         foreach (live_settings[k]) begin
            live_settings[k] = 8'h00;
            staged_settings[k] = 8'h00;
         end
      end else begin
         // predict first so a same-cycle result would still find its expectation
         req_done = req_valid && req_ready;
         if (req_done) parse_frame_byte(req_rx_byte, req_frame_start);
         if (rsp_valid && rsp_ready) begin
            if (awaited_tx_q.size() == 0) begin
               report_error($sformatf("reply byte %0d with none expected: tx_byte %02h",
                                      tx_seen, rsp_tx_byte));
            end else begin
               want = awaited_tx_q.pop_front();
               if (rsp_tx_byte !== want.tx_byte)
                  report_error($sformatf("reply byte %0d tx_byte %02h, expected %02h",
                                         tx_seen, rsp_tx_byte, want.tx_byte));
               if (rsp_tx_last !== want.tx_last)
                  report_error($sformatf("reply byte %0d tx_last %b, expected %b",
                                         tx_seen, rsp_tx_last, want.tx_last));
               if (rsp_rejected !== want.rejected)
                  report_error($sformatf("reply byte %0d rejected %b, expected %b",
                                         tx_seen, rsp_rejected, want.rejected));
            end
            tx_seen++;
         end
      end
      tail_calm = byte_feed_q.size() < 40;
   end

   // ---------------------------------------------------------------
   // stimulus, reset and end of run
   // ---------------------------------------------------------------
   initial begin
      logic [7:0] b;
      int         kind;
      int         n;
      bit         hold;

      // directed: stray byte, read of the cleared store, bad first byte, full write
      queue_byte(8'h00, 1'b0, 1'b0, 1'b1);
      queue_header(HEADER_BYTES, 1'b0);
      queue_byte(CMD_READ, 1'b0, 1'b0, 1'b0);
      // waits out the read reply, then mismatches on header byte 0
      queue_byte(8'h00, 1'b1, 1'b1, 1'b0);
      queue_header(HEADER_BYTES, 1'b0);
      queue_byte(CMD_WRITE, 1'b0, 1'b0, 1'b0);
      for (int k = 0; k < SETTING_BYTES; k++) begin
         if (k == 0) b = 8'h00;
         else if (k == 1) b = 8'hFF;
         else b = {4'(k), ~4'(k)};
         queue_byte(b, 1'b0, 1'b0, 1'b0);
      end

      // random frames, mostly well formed so writes and reads get through
      while (stimulus_count < 120) begin
         hold = ($urandom_range(0, 5) == 0);
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            queue_header(HEADER_BYTES, hold);
            queue_byte(CMD_READ, 1'b0, 1'b0, 1'b0);
         end else if (kind < 50) begin
            queue_header(HEADER_BYTES, hold);
            queue_byte(CMD_WRITE, 1'b0, 1'b0, 1'b0);
            for (int k = 0; k < SETTING_BYTES; k++)
               queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
         end else if (kind < 58) begin
            // write cut short; the next frame start must drop it
            queue_header(HEADER_BYTES, hold);
            queue_byte(CMD_WRITE, 1'b0, 1'b0, 1'b0);
            n = $urandom_range(0, SETTING_BYTES - 1);
            for (int k = 0; k < n; k++)
               queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
         end else if (kind < 68) begin
            // header mismatch at a random position
            n = $urandom_range(0, HEADER_BYTES - 1);
            queue_header(n, hold);
            do b = 8'($urandom_range(0, 255)); while (b == FRAME_HEADER[n]);
            queue_byte(b, logic'(n == 0), hold && n == 0, 1'b0);
         end else if (kind < 78) begin
            // unknown control byte
            queue_header(HEADER_BYTES, hold);
            do b = 8'($urandom_range(0, 255)); while (b == CMD_READ || b == CMD_WRITE);
            queue_byte(b, 1'b0, 1'b0, 1'b0);
         end else if (kind < 86) begin
            // header abandoned part way
            queue_header($urandom_range(1, HEADER_BYTES - 1), hold);
         end else if (kind < 94) begin
            // noise without frame start
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++)
               queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
         end else begin
            // fully random bytes, frame start included
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++)
               queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
                          1'b0);
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every request sent and taken
      do @(posedge clock); while (byte_feed_q.size() != 0 || req_valid);
      // replies drain; a full reply is the mark and SETTING_BYTES stored bytes
      for (int w = 0; w < 3000 && awaited_tx_q.size() != 0; w++) @(negedge clock);
      repeat (40) @(negedge clock);
      if (awaited_tx_q.size() != 0)
         report_error($sformatf("%0d reply bytes never arrived", awaited_tx_q.size()));

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin
      #6_000_000;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
